### hw/rtl/websocket_frame_deframer_defines.svh
// Assertion macros for the WebSocket frame deframer.
// Depends on nothing; included by the top level only.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
`define WSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSD_ASSERT(label, clk, rst, prop, msg)
`define WSD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsd_parser and websocket_frame_deframer.
package wsd_pkg;

   localparam int FrameByteW = 8;
   localparam int OpcodeW    = 4;
   localparam int LengthW    = 64;
   localparam int ExtCountW  = 4;
   localparam int KeyBytes   = 4;
   localparam int KeyIdxW    = 2;
   localparam int PhaseW     = 3;

   localparam logic [OpcodeW-1:0] OP_CLOSE = 4'd8;

   localparam logic [6:0] LEN7_MAX  = 7'd125;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;

   localparam logic [ExtCountW-1:0] EXT16_BYTES = 4'd2;
   localparam logic [ExtCountW-1:0] EXT64_BYTES = 4'd8;

   localparam logic [PhaseW-1:0] PH_FIRST = 3'd0;
   localparam logic [PhaseW-1:0] PH_LEN   = 3'd1;
   localparam logic [PhaseW-1:0] PH_EXT   = 3'd2;
   localparam logic [PhaseW-1:0] PH_MASK  = 3'd3;
   localparam logic [PhaseW-1:0] PH_DATA  = 3'd4;
   localparam logic [PhaseW-1:0] PH_SKIP  = 3'd5;

   typedef struct packed {
      logic                  emit;
      logic [FrameByteW-1:0] payload_byte;
      logic                  payload_valid;
      logic                  frame_last;
      logic                  fin_flag;
      logic [OpcodeW-1:0]    frame_opcode;
      logic                  close_seen;
      logic                  length_mismatch;
   } wsd_result_type;

endpackage

### hw/rtl/wsd_parser.sv
// Header parser, length check and payload unmasking for one frame byte.
// Depends on wsd_pkg; instantiated by websocket_frame_deframer.
module wsd_parser
   import wsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [FrameByteW-1:0] frame_byte,
   input  logic                  frame_end,
   output wsd_result_type        result
);

   logic [PhaseW-1:0]     phase_ff, phase_in;
   logic [ExtCountW-1:0]  ext_left_ff, ext_left_in;
   logic [LengthW-1:0]    declared_ff, declared_in;
   logic [LengthW-1:0]    count_ff, count_in;
   logic [FrameByteW-1:0] key_ff [KeyBytes];
   logic [FrameByteW-1:0] key_in [KeyBytes];
   logic [KeyIdxW-1:0]    key_idx_ff, key_idx_in;
   logic                  fin_ff, fin_in;
   logic [OpcodeW-1:0]    opcode_ff, opcode_in;
   logic [6:0]            len7;

   assign len7 = frame_byte[6:0];

   always_comb begin
      phase_in    = phase_ff;
      ext_left_in = ext_left_ff;
      declared_in = declared_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      key_idx_in  = key_idx_ff;
      fin_in      = fin_ff;
      opcode_in   = opcode_ff;
      result      = '0;
      unique case (phase_ff)
         PH_LEN: begin
            if (len7 <= LEN7_MAX) begin
               declared_in = {{(LengthW-7){1'b0}}, len7};
               phase_in    = PH_MASK;
            end else begin
               declared_in = '0;
               ext_left_in = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               phase_in    = PH_EXT;
            end
            result.emit            = frame_end;
            result.length_mismatch = frame_end;
         end
         PH_EXT: begin
            declared_in = {declared_ff[LengthW-FrameByteW-1:0], frame_byte};
            ext_left_in = ext_left_ff - 1'b1;
            if (ext_left_in == '0) begin
               phase_in = PH_MASK;
            end
            result.emit            = frame_end;
            result.length_mismatch = frame_end;
         end
         PH_MASK: begin
            key_in[key_idx_ff] = frame_byte;
            result.emit        = frame_end;
            if (key_idx_ff == KeyIdxW'(KeyBytes - 1)) begin
               key_idx_in             = '0;
               phase_in               = PH_DATA;
               result.length_mismatch = frame_end && (declared_ff != '0);
            end else begin
               key_idx_in             = key_idx_ff + 1'b1;
               result.length_mismatch = frame_end;
            end
         end
         PH_DATA: begin
            key_idx_in             = key_idx_ff + 1'b1;
            count_in               = count_ff + 1'b1;
            result.emit            = 1'b1;
            result.payload_valid   = 1'b1;
            result.payload_byte    = frame_byte ^ key_ff[key_idx_ff];
            result.length_mismatch = frame_end && (count_in != declared_ff);
         end
         PH_SKIP: begin
            result.emit = frame_end;
         end
         default: begin
            fin_in    = frame_byte[7];
            opcode_in = frame_byte[OpcodeW-1:0];
            result.emit = frame_end;
            if (opcode_in == OP_CLOSE) begin
               phase_in = PH_SKIP;
            end else begin
               phase_in               = PH_LEN;
               result.length_mismatch = frame_end;
            end
         end
      endcase
      result.frame_last   = frame_end;
      result.fin_flag     = fin_in;
      result.frame_opcode = opcode_in;
      result.close_seen   = (opcode_in == OP_CLOSE);
      if (frame_end) begin
         phase_in    = PH_FIRST;
         ext_left_in = '0;
         declared_in = '0;
         count_in    = '0;
         key_idx_in  = '0;
         for (int i = 0; i < KeyBytes; i++) begin
            key_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         ext_left_ff <= '0;
         declared_ff <= '0;
         count_ff    <= '0;
         key_idx_ff  <= '0;
         fin_ff      <= 1'b0;
         opcode_ff   <= '0;
         for (int i = 0; i < KeyBytes; i++) begin
            key_ff[i] <= '0;
         end
      end else if (step) begin
         phase_ff    <= phase_in;
         ext_left_ff <= ext_left_in;
         declared_ff <= declared_in;
         count_ff    <= count_in;
         key_idx_ff  <= key_idx_in;
         fin_ff      <= fin_in;
         opcode_ff   <= opcode_in;
         key_ff      <= key_in;
      end
   end

endmodule

### hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer: takes one frame byte per transfer, with frame_end on the
// frame's last byte, parses FIN, opcode, 7/16/64-bit length and the 4-byte mask key,
// and returns each payload byte unmasked. A close frame returns one result at its end;
// every frame closes with a result marked frame_last that flags a length mismatch or a
// truncated header. Header bytes return nothing unless they end the frame. One byte is
// taken every cycle while req_ready is high; a result appears in the cycle after its
// byte, held in a single output register that is refilled in the same cycle it is taken,
// so req_ready drops only while that register holds a result that rsp_ready has not taken.
// Depends on wsd_pkg, wsd_parser and websocket_frame_deframer_defines.svh.
`include "websocket_frame_deframer_defines.svh"
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FrameByteW-1:0] req_frame_byte,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FrameByteW-1:0] rsp_payload_byte,
   output logic                  rsp_payload_valid,
   output logic                  rsp_frame_last,
   output logic                  rsp_fin_flag,
   output logic [OpcodeW-1:0]    rsp_frame_opcode,
   output logic                  rsp_close_seen,
   output logic                  rsp_length_mismatch
);

   logic           accept;
   logic           rsp_valid_ff, rsp_valid_in;
   wsd_result_type result;
   wsd_result_type rsp_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .frame_byte (req_frame_byte),
      .frame_end  (req_frame_end),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = result.emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload until the next result transfer
   always_ff @(posedge clock) begin
      if (accept && result.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_byte    = rsp_ff.payload_byte;
   assign rsp_payload_valid   = rsp_ff.payload_valid;
   assign rsp_frame_last      = rsp_ff.frame_last;
   assign rsp_fin_flag        = rsp_ff.fin_flag;
   assign rsp_frame_opcode    = rsp_ff.frame_opcode;
   assign rsp_close_seen      = rsp_ff.close_seen;
   assign rsp_length_mismatch = rsp_ff.length_mismatch;

   `WSD_ASSERT(a_ready_only_blocked_by_rsp, clock, reset, !req_ready |-> rsp_valid, "req_ready low without a pending result")
   `WSD_ASSERT(a_mismatch_on_last, clock, reset, rsp_valid && rsp_length_mismatch |-> rsp_frame_last, "length mismatch on a result that is not last")
   `WSD_ASSERT(a_close_no_payload, clock, reset, rsp_valid && rsp_close_seen |-> !rsp_payload_valid && rsp_frame_last && !rsp_length_mismatch, "close result carries payload or mismatch")
   `WSD_ASSERT(a_empty_byte_zero, clock, reset, rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == '0 && rsp_frame_last, "non-payload result not last or byte nonzero")

endmodule
